/* rtl/dda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_pkg
// Shared constants for the DDA line rasterizer: default widths, opcodes and
// the depth of the command queue between front and back.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int COORD_BITS_DEF = 10;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH    = 2;

    // Input item kinds carried on tuser
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_STEP = 1'b1;

endpackage

/* rtl/dda_line_rasterizer.sv */
`timescale 1ns / 1ps
// A step item is written into the queue, then popped by the back into the
// registered output slot; a load occupies the back for a setup step, then
// the divider forms one quotient bit per cycle.
// Throughput: one pixel per cycle while the output drains and no load is
// dividing; the serial divider sets the cost of each load. rst_n clears
// the queue, line state and output register; after reset no line is active.
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: a front classifies load and step items and computes
// axis distances, a two-entry queue decouples it from the back, and the back
// divides for the minor axis increment and walks the accumulators.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
    parameter int IN_TDATA_W  = ((4 * COORD_BITS + 7) / 8) * 8,
    parameter int OUT_TDATA_W = ((2 * COORD_BITS + 7) / 8) * 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    // input items
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_x, start_y, end_x, end_y (low bit first), zero padded
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // opcode: 0 load endpoints, 1 emit next pixel
    input  logic                   s_axis_tuser,
    // result items
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // pixel_x, pixel_y (low bit first), zero padded
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // last_pixel
    output logic                   m_axis_tlast
);
    import dda_pkg::*;

    localparam int CMD_W = 4 * COORD_BITS + 3;

    logic [CMD_W-1:0]      front_cmd;
    logic [CMD_W-1:0]      queue_cmd;
    logic                  queue_full;
    logic                  queue_empty;
    logic                  queue_pop;
    logic [COORD_BITS-1:0] pixel_x;
    logic [COORD_BITS-1:0] pixel_y;

    // classify the item and precompute distances and directions
    dda_front #(
        .COORD_BITS (COORD_BITS),
        .CMD_W      (CMD_W)
    ) u_front (
        .opcode  (s_axis_tuser),
        .start_x (s_axis_tdata[0 * COORD_BITS +: COORD_BITS]),
        .start_y (s_axis_tdata[1 * COORD_BITS +: COORD_BITS]),
        .end_x   (s_axis_tdata[2 * COORD_BITS +: COORD_BITS]),
        .end_y   (s_axis_tdata[3 * COORD_BITS +: COORD_BITS]),
        .cmd     (front_cmd)
    );

    // accept whenever the queue has room
    assign s_axis_tready = !queue_full;

    dda_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_axis_tvalid),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .empty     (queue_empty),
        .pop_data  (queue_cmd)
    );

    // line setup, division and pixel walk, with a registered output slot
    dda_back #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .CMD_W      (CMD_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_empty  (queue_empty),
        .cmd        (queue_cmd),
        .cmd_pop    (queue_pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .last_pixel (m_axis_tlast)
    );

    // pack the pixel and fill the upper bits with zeros
    assign m_axis_tdata = OUT_TDATA_W'({pixel_y, pixel_x});

endmodule

/* rtl/dda_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_front
// Classify an input item and turn a load into per-axis distance and
// direction, packed as one queue command.
// Command layout, low bit first:
//   is_step, start_x, start_y, abs_dx, abs_dy, neg_x, neg_y
// ----------------------------------------------------------------------------
module dda_front #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int CMD_W      = 4 * dda_pkg::COORD_BITS_DEF + 3
) (
    input  logic                  opcode,
    input  logic [COORD_BITS-1:0] start_x,
    input  logic [COORD_BITS-1:0] start_y,
    input  logic [COORD_BITS-1:0] end_x,
    input  logic [COORD_BITS-1:0] end_y,
    output logic [CMD_W-1:0]      cmd
);
    import dda_pkg::*;

    logic                  neg_x;
    logic                  neg_y;
    logic [COORD_BITS-1:0] abs_dx;
    logic [COORD_BITS-1:0] abs_dy;

    always_comb
    begin
        neg_x  = end_x < start_x;
        neg_y  = end_y < start_y;
        abs_dx = neg_x ? (start_x - end_x) : (end_x - start_x);
        abs_dy = neg_y ? (start_y - end_y) : (end_y - start_y);
        cmd    = {neg_y, neg_x, abs_dy, abs_dx, start_y, start_x, opcode == OP_STEP};
    end

endmodule

/* rtl/dda_cmd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_cmd_fifo
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dda_cmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = dda_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] pop_data
);
    import dda_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign full     = count_reg == CW'(DEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/dda_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dda_back
// Execute queued commands: set up a line with a bit-serial division for the
// minor axis increment, then emit one pixel per step from the accumulators.
// ----------------------------------------------------------------------------
module dda_back #(
    parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF,
    parameter int CMD_W      = 4 * dda_pkg::COORD_BITS_DEF + 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_empty,
    input  logic [CMD_W-1:0]      cmd,
    output logic                  cmd_pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [COORD_BITS-1:0] pixel_x,
    output logic [COORD_BITS-1:0] pixel_y,
    output logic                  last_pixel
);
    import dda_pkg::*;

    localparam int AW  = COORD_BITS + FRAC_BITS + 1;
    localparam int IW  = FRAC_BITS + 2;
    localparam int QW  = FRAC_BITS + 1;
    localparam int LW  = COORD_BITS + 1;
    localparam int CNW = $clog2(FRAC_BITS);

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_DIV = 1'b1;

    localparam logic [IW-1:0] UNIT_INC = IW'(1) << FRAC_BITS;

    // command fields
    logic                  c_step;
    logic [COORD_BITS-1:0] c_sx;
    logic [COORD_BITS-1:0] c_sy;
    logic [COORD_BITS-1:0] c_adx;
    logic [COORD_BITS-1:0] c_ady;
    logic                  c_negx;
    logic                  c_negy;

    logic                  state_reg,    state_next;
    logic [CNW-1:0]        cnt_reg,      cnt_next;
    logic [COORD_BITS-1:0] rem_reg,      rem_next;
    logic [QW-1:0]         quo_reg,      quo_next;
    logic [COORD_BITS-1:0] steps_reg,    steps_next;
    logic                  minor_x_reg,  minor_x_next;
    logic                  neg_x_reg,    neg_x_next;
    logic                  neg_y_reg,    neg_y_next;
    logic [AW-1:0]         x_acc_reg,    x_acc_next;
    logic [AW-1:0]         y_acc_reg,    y_acc_next;
    logic [IW-1:0]         x_inc_reg,    x_inc_next;
    logic [IW-1:0]         y_inc_reg,    y_inc_next;
    logic [LW-1:0]         left_reg,     left_next;
    logic                  ov_reg,       ov_next;
    logic [COORD_BITS-1:0] px_reg,       px_next;
    logic [COORD_BITS-1:0] py_reg,       py_next;
    logic                  last_reg,     last_next;

    logic                  out_free;
    logic                  x_major;
    logic [COORD_BITS-1:0] steps_w;
    logic [COORD_BITS-1:0] minor_w;
    logic [COORD_BITS:0]   rem_shift;
    logic                  q_bit;
    logic [IW-1:0]         minor_inc;
    logic [IW-1:0]         major_x_inc;
    logic [IW-1:0]         major_y_inc;

    assign {c_negy, c_negx, c_ady, c_adx, c_sy, c_sx, c_step} = cmd;

    assign out_valid  = ov_reg;
    assign pixel_x    = px_reg;
    assign pixel_y    = py_reg;
    assign last_pixel = last_reg;

    always_comb
    begin
        out_free    = !ov_reg || out_ready;
        x_major     = c_adx > c_ady;
        steps_w     = x_major ? c_adx : c_ady;
        minor_w     = x_major ? c_ady : c_adx;
        rem_shift   = {rem_reg, 1'b0};
        q_bit       = rem_shift >= {1'b0, steps_reg};
        // quotient including the bit formed this cycle
        minor_inc   = {1'b0, quo_reg[QW-2:0], q_bit};
        major_x_inc = neg_x_reg ? (~UNIT_INC + 1'b1) : UNIT_INC;
        major_y_inc = neg_y_reg ? (~UNIT_INC + 1'b1) : UNIT_INC;

        state_next   = state_reg;
        cnt_next     = cnt_reg;
        rem_next     = rem_reg;
        quo_next     = quo_reg;
        steps_next   = steps_reg;
        minor_x_next = minor_x_reg;
        neg_x_next   = neg_x_reg;
        neg_y_next   = neg_y_reg;
        x_acc_next   = x_acc_reg;
        y_acc_next   = y_acc_reg;
        x_inc_next   = x_inc_reg;
        y_inc_next   = y_inc_reg;
        left_next    = left_reg;
        ov_next      = ov_reg && !out_ready;
        px_next      = px_reg;
        py_next      = py_reg;
        last_next    = last_reg;
        cmd_pop      = 1'b0;

        unique case (state_reg)
            ST_RUN:
            begin
                if (!cmd_empty)
                begin
                    if (!c_step)
                    begin
                        // load: start point, step count, kick off the division
                        cmd_pop      = 1'b1;
                        x_acc_next   = AW'(c_sx) << FRAC_BITS;
                        y_acc_next   = AW'(c_sy) << FRAC_BITS;
                        left_next    = LW'(steps_w);
                        steps_next   = steps_w;
                        minor_x_next = !x_major;
                        neg_x_next   = c_negx;
                        neg_y_next   = c_negy;
                        x_inc_next   = '0;
                        y_inc_next   = '0;
                        cnt_next     = CNW'(FRAC_BITS - 1);
                        if (minor_w == steps_w)
                        begin
                            quo_next = QW'(1);
                            rem_next = '0;
                        end
                        else
                        begin
                            quo_next = '0;
                            rem_next = minor_w;
                        end
                        if (steps_w != '0)
                        begin
                            state_next = ST_DIV;
                        end
                    end
                    else if (left_reg == '0)
                    begin
                        // step with no active line: drop it
                        cmd_pop = 1'b1;
                    end
                    else if (out_free)
                    begin
                        cmd_pop    = 1'b1;
                        ov_next    = 1'b1;
                        px_next    = x_acc_reg[FRAC_BITS +: COORD_BITS];
                        py_next    = y_acc_reg[FRAC_BITS +: COORD_BITS];
                        last_next  = left_reg == LW'(1);
                        x_acc_next = x_acc_reg + {{(AW - IW){x_inc_reg[IW-1]}}, x_inc_reg};
                        y_acc_next = y_acc_reg + {{(AW - IW){y_inc_reg[IW-1]}}, y_inc_reg};
                        left_next  = left_reg - 1'b1;
                    end
                end
            end
            ST_DIV:
            begin
                // one quotient bit per cycle
                rem_next = q_bit ? COORD_BITS'(rem_shift - {1'b0, steps_reg})
                                 : rem_shift[COORD_BITS-1:0];
                quo_next = {quo_reg[QW-2:0], q_bit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = ST_RUN;
                    if (minor_x_reg)
                    begin
                        x_inc_next = neg_x_reg ? (~minor_inc + 1'b1) : minor_inc;
                        y_inc_next = major_y_inc;
                    end
                    else
                    begin
                        x_inc_next = major_x_inc;
                        y_inc_next = neg_y_reg ? (~minor_inc + 1'b1) : minor_inc;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_RUN;
            cnt_reg     <= '0;
            rem_reg     <= '0;
            quo_reg     <= '0;
            steps_reg   <= '0;
            minor_x_reg <= 1'b0;
            neg_x_reg   <= 1'b0;
            neg_y_reg   <= 1'b0;
            x_acc_reg   <= '0;
            y_acc_reg   <= '0;
            x_inc_reg   <= '0;
            y_inc_reg   <= '0;
            left_reg    <= '0;
            ov_reg      <= 1'b0;
            px_reg      <= '0;
            py_reg      <= '0;
            last_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            rem_reg     <= rem_next;
            quo_reg     <= quo_next;
            steps_reg   <= steps_next;
            minor_x_reg <= minor_x_next;
            neg_x_reg   <= neg_x_next;
            neg_y_reg   <= neg_y_next;
            x_acc_reg   <= x_acc_next;
            y_acc_reg   <= y_acc_next;
            x_inc_reg   <= x_inc_next;
            y_inc_reg   <= y_inc_next;
            left_reg    <= left_next;
            ov_reg      <= ov_next;
            px_reg      <= px_next;
            py_reg      <= py_next;
            last_reg    <= last_next;
        end
    end

endmodule

/* tb/sv/tb_dda_line_rasterizer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dda_line_rasterizer
// Self-checking bench for the DDA line rasterizer. An initial block queues
// load and step items. A clocked driver feeds them to the slave side with
// random gaps. A clocked monitor drains the master side with random stalls.
// Every accepted item runs through a local line walker: a load sets up the
// line and a step queues the pixel it predicts. Each pixel that comes out
// is checked against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module tb_dda_line_rasterizer;

    import dda_pkg::*;

    localparam int CB          = COORD_BITS_DEF;
    localparam int FB          = FRAC_BITS_DEF;
    localparam int IN_W        = ((4 * CB + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * CB + 7) / 8) * 8;
    localparam int COORD_MAX   = (1 << CB) - 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int CALM_TAIL   = 120;   // items left when idling stops

    typedef struct {
        logic          op;
        logic [CB-1:0] sx;
        logic [CB-1:0] sy;
        logic [CB-1:0] ex;
        logic [CB-1:0] ey;
        bit            drain;   // hold this item until every pixel is out
    } line_cmd_t;

    typedef struct {
        logic [CB-1:0] px;
        logic [CB-1:0] py;
        logic          last;
    } pixel_t;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;    // start_x, start_y, end_x, end_y
    logic              s_axis_tuser;    // opcode
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;    // pixel_x, pixel_y, zero padded
    logic              m_axis_tlast;    // last_pixel

    // Local copy of the walker state
    logic signed [CB+FB:0] x_pos;
    logic signed [CB+FB:0] y_pos;
    logic signed [FB+1:0]  x_slope;
    logic signed [FB+1:0]  y_slope;
    logic [CB:0]           pixels_to_go;

    line_cmd_t cmd_q[$];
    pixel_t    pixel_due_q[$];

    int  fault_count;
    int  send_gap;
    int  ready_run;
    logic ready_lvl;
    logic steady;
    int  cycle_count;

    dda_line_rasterizer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
    end

    task automatic report_fault(input string what);
    begin
        $display("mismatch at %0t: %s", $realtime, what);
        fault_count++;
    end
    endtask

    // Fixed-point slope d / span, truncated toward zero; span is never zero
    function automatic logic signed [FB+1:0] axis_slope(input int d, input int span);
        int mag;
    begin
        mag = ((d < 0 ? -d : d) << FB) / span;
        return (FB+2)'((d < 0) ? -mag : mag);
    end
    endfunction

    // Walk one accepted item: a load sets up the line, a step queues a pixel
    task automatic walk_line(input logic op, input logic [IN_W-1:0] d);
        int sx;
        int sy;
        int dx;
        int dy;
        int span;
    begin
        if (op == OP_LOAD)
        begin
            sx   = int'(d[CB-1:0]);
            sy   = int'(d[2*CB-1:CB]);
            dx   = int'(d[3*CB-1:2*CB]) - sx;
            dy   = int'(d[4*CB-1:3*CB]) - sy;
            span = (dx < 0 ? -dx : dx);
            if ((dy < 0 ? -dy : dy) > span)
                span = (dy < 0 ? -dy : dy);
            x_pos = {1'b0, d[CB-1:0], {FB{1'b0}}};
            y_pos = {1'b0, d[2*CB-1:CB], {FB{1'b0}}};
            if (span == 0)
            begin
                x_slope      = '0;
                y_slope      = '0;
                pixels_to_go = '0;
            end
            else
            begin
                x_slope      = axis_slope(dx, span);
                y_slope      = axis_slope(dy, span);
                pixels_to_go = (CB+1)'(span);
            end
        end
        else if (pixels_to_go != 0)
        begin
            // floor of the position, kept to the coordinate width
            pixel_due_q.push_back('{px: x_pos[CB+FB-1:FB], py: y_pos[CB+FB-1:FB],
                                    last: (pixels_to_go == 1)});
            x_pos        = x_pos + x_slope;
            y_pos        = y_pos + y_slope;
            pixels_to_go = pixels_to_go - 1'b1;
        end
    end
    endtask

    // ------------------------------------------------------------------
    // Driver: present queued items, hold each until accepted, insert gaps
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= OP_LOAD;
            steady        <= 1'b0;
            send_gap      = 0;
            x_pos         = '0;
            y_pos         = '0;
            x_slope       = '0;
            y_slope       = '0;
            pixels_to_go  = '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                walk_line(s_axis_tuser, s_axis_tdata);
                if (cmd_q.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 12);
            end
            steady <= (cmd_q.size() < CALM_TAIL);
            // advance only when the bus is free or the item just left
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (cmd_q.size() != 0 &&
                         !(cmd_q[0].drain && pixel_due_q.size() != 0))
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tuser  <= cmd_q[0].op;
                    s_axis_tdata  <= {cmd_q[0].ey, cmd_q[0].ex, cmd_q[0].sy, cmd_q[0].sx};
                    void'(cmd_q.pop_front());
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check each pixel, stall the output in random bursts
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            ready_run     = 0;
            ready_lvl     = 1'b1;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pixel_due_q.size() == 0)
                begin
                    report_fault($sformatf("unexpected pixel (%0d,%0d)",
                                           m_axis_tdata[CB-1:0], m_axis_tdata[2*CB-1:CB]));
                end
                else
                begin
                    want = pixel_due_q.pop_front();
                    if (m_axis_tdata[CB-1:0] !== want.px)
                        report_fault($sformatf("pixel_x %0d, want %0d",
                                               m_axis_tdata[CB-1:0], want.px));
                    if (m_axis_tdata[2*CB-1:CB] !== want.py)
                        report_fault($sformatf("pixel_y %0d, want %0d",
                                               m_axis_tdata[2*CB-1:CB], want.py));
                    if (m_axis_tlast !== want.last)
                        report_fault($sformatf("last_pixel %0b, want %0b",
                                               m_axis_tlast, want.last));
                end
            end
            if (steady)
            begin
                m_axis_tready <= 1'b1;
            end
            else
            begin
                if (ready_run == 0)
                begin
                    ready_lvl = ($urandom_range(0, 3) != 0);
                    ready_run = ready_lvl ? $urandom_range(1, 20) : $urandom_range(1, 12);
                end
                ready_run--;
                m_axis_tready <= ready_lvl;
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Stimulus and end of run
    task automatic add_load(input int sx, input int sy, input int ex, input int ey,
                            input bit drain);
    begin
        cmd_q.push_back('{op: OP_LOAD, sx: CB'(sx), sy: CB'(sy), ex: CB'(ex), ey: CB'(ey),
                          drain: drain});
    end
    endtask

    task automatic add_steps(input int n);
    begin
        repeat (n)
            cmd_q.push_back('{op: OP_STEP, sx: CB'($urandom), sy: CB'($urandom),
                              ex: CB'($urandom), ey: CB'($urandom), drain: 1'b0});
    end
    endtask

    // Random coordinate within reach of c, clamped to the raster
    function automatic int near(input int c, input int reach);
        int v;
    begin
        v = c + int'($urandom_range(0, 2 * reach)) - reach;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v;
    end
    endfunction

    initial
    begin
        int made;
        int pick;
        int reach;
        int sx;
        int sy;
        int ex;
        int ey;
        int span;
        int n;
        int next_drain;

        fault_count = 0;
        cycle_count = 0;

        // step with no line active after reset: nothing comes out
        add_steps(1);
        // anti-diagonal across the whole raster, cut short by a new load
        add_load(0, COORD_MAX, COORD_MAX, 0, 1'b0);
        add_steps(3);
        add_load(COORD_MAX, 0, 0, COORD_MAX, 1'b0);
        add_steps(2);
        // equal endpoints: no pixels, steps stay silent
        add_load(512, 512, 512, 512, 1'b0);
        add_steps(2);
        // steep line walked to its end, plus one step past it
        add_load(10, 10, 12, 17, 1'b1);
        add_steps(8);
        // shallow line going left and up, ending at the raster edge
        add_load(5, 2, 0, 0, 1'b0);
        add_steps(5);

        made       = 0;
        next_drain = 0;
        while (made < 950)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
            begin
                // well-formed line, mostly short, walked to its end or beyond or cut short
                reach = ($urandom_range(0, 9) == 0) ? 48 : 8;
                sx    = $urandom_range(0, COORD_MAX);
                sy    = $urandom_range(0, COORD_MAX);
                ex    = near(sx, reach);
                ey    = near(sy, reach);
                span  = (ex > sx) ? ex - sx : sx - ex;
                if (((ey > sy) ? ey - sy : sy - ey) > span)
                    span = (ey > sy) ? ey - sy : sy - ey;
                n = span + $urandom_range(0, 1);
                if ($urandom_range(0, 3) == 0)
                    n = $urandom_range(0, span + 2);
                add_load(sx, sy, ex, ey, made >= next_drain);
                if (made >= next_drain)
                    next_drain += 200;
                add_steps(n);
                made += 1 + n;
            end
            else if (pick < 95)
            begin
                // arbitrary endpoints, a few pixels only
                n = $urandom_range(0, 3);
                add_load($urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX),
                         $urandom_range(0, COORD_MAX), $urandom_range(0, COORD_MAX), 1'b0);
                add_steps(n);
                made += 1 + n;
            end
            else
            begin
                n = $urandom_range(1, 3);
                add_steps(n);
                made += n;
            end
        end

        // drain the input, then the expected pixels, then let the back settle
        @(posedge clk);
        while (cmd_q.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        while (pixel_due_q.size() != 0)
            @(posedge clk);
        repeat (2 * FB + 8) @(posedge clk);

        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/dda_pkg.sv
rtl/dda_front.sv
rtl/dda_cmd_fifo.sv
rtl/dda_back.sv
rtl/dda_line_rasterizer.sv
tb/sv/tb_dda_line_rasterizer.sv
